>>> rtl/bclpd_pkg.sv
// ----------------------------------------------------------------------------
// bclpd_pkg: button click / long press detector package
// Shared types, codes and sizes for the detector and its cell chain.
// ----------------------------------------------------------------------------
package bclpd_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int TIMER_BITS  = 16;
  localparam int CFG_BITS    = 16;
  localparam int MAX_RES     = 4;
  localparam int CMP_W       = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam int RES_IDX_W   = $clog2(MAX_RES);
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_LONG    = 2'd1;
  localparam logic [1:0] EV_CLICKS  = 2'd2;

  localparam logic [3:0] TALLY_MAX  = 4'd15;

  localparam logic REG_LONG_PRESS  = 1'b0;
  localparam logic REG_RELEASE_GAP = 1'b1;

  localparam logic [CFG_BITS-1:0] LONG_PRESS_RST  = 16'd500;
  localparam logic [CFG_BITS-1:0] RELEASE_GAP_RST = 16'd25;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_HELD      = 4'b0010,
    MODE_RELEASED  = 4'b0100,
    MODE_LONG_DONE = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       key_valid;
    logic [4:0] key_number;
  } item_t;

  typedef struct packed {
    logic [4:0] button_number;
    logic [1:0] event_res;
    logic [3:0] click_count;
    logic       busy_res;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] long_press_ticks;
    logic [CFG_BITS-1:0] release_gap_ticks;
  } cfg_t;

  // item walking down the chain; btn is the one-based number of the next cell
  typedef struct packed {
    logic       act;
    logic [1:0] opcode;
    logic       key_valid;
    logic [4:0] key_number;
    logic [4:0] btn;
  } token_t;

  typedef struct packed {
    logic       fire;
    logic [4:0] btn;
    logic [1:0] ev;
    logic [3:0] cnt;
  } event_t;

endpackage

>>> rtl/bclpd_cell.sv
// ----------------------------------------------------------------------------
// bclpd_cell: one button cell
// Holds mode, click tally and tick counter of one button; applies the word
// passing through and hands it on to the next cell.
// ----------------------------------------------------------------------------
module bclpd_cell (
  input  logic              clk,
  input  logic              rst,
  input  bclpd_pkg::cfg_t   cfg,
  input  bclpd_pkg::token_t token_in,
  output bclpd_pkg::token_t token_out,
  output bclpd_pkg::event_t evt,
  output logic              tally_nz
);
  import bclpd_pkg::*;

  mode_t                 mode, mode_next;
  logic [3:0]            tally, tally_next;
  logic [TIMER_BITS-1:0] elapsed, elapsed_next;
  logic [TIMER_BITS-1:0] inc;
  logic                  hit;

  assign tally_nz = (tally != 4'd0);
  assign hit = token_in.key_valid && (token_in.key_number == token_in.btn);
  assign inc = (elapsed != {TIMER_BITS{1'b1}}) ? elapsed + TIMER_BITS'(1) : elapsed;

  always_comb begin
    mode_next    = mode;
    tally_next   = tally;
    elapsed_next = elapsed;
    evt          = '0;
    evt.btn      = token_in.btn;
    if (token_in.act) begin
      case (token_in.opcode)
        OP_TICK: begin
          elapsed_next = inc;
          if (mode == MODE_HELD &&
              CMP_W'(inc) > CMP_W'(cfg.long_press_ticks)) begin
            mode_next  = MODE_LONG_DONE;
            tally_next = 4'd0;
            evt.fire   = 1'b1;
            evt.ev     = EV_LONG;
          end else if (mode == MODE_RELEASED &&
                       CMP_W'(inc) > CMP_W'(cfg.release_gap_ticks)) begin
            mode_next  = MODE_IDLE;
            tally_next = 4'd0;
            evt.fire   = 1'b1;
            evt.ev     = EV_CLICKS;
            evt.cnt    = tally;
          end
        end
        OP_PRESS: begin
          if (hit) begin
            mode_next    = MODE_HELD;
            elapsed_next = '0;
            if (tally != TALLY_MAX) tally_next = tally + 4'd1;
          end
        end
        OP_RELEASE: begin
          if (hit) begin
            mode_next    = MODE_RELEASED;
            elapsed_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      tally         <= 4'd0;
      elapsed       <= '0;
      token_out.act <= 1'b0;
    end else begin
      mode          <= mode_next;
      tally         <= tally_next;
      elapsed       <= elapsed_next;
      token_out.act <= token_in.act;
    end
  end

  always_ff @(posedge clk) begin
    token_out.opcode     <= token_in.opcode;
    token_out.key_valid  <= token_in.key_valid;
    token_out.key_number <= token_in.key_number;
    token_out.btn        <= token_in.btn + 5'd1;
  end

endmodule

>>> rtl/bclpd_chain.sv
// ----------------------------------------------------------------------------
// bclpd_chain: row of button cells
// The word steps one cell per cycle; at most one cell is active at a time,
// so the cell events merge by OR.
// ----------------------------------------------------------------------------
module bclpd_chain (
  input  logic              clk,
  input  logic              rst,
  input  bclpd_pkg::cfg_t   cfg,
  input  bclpd_pkg::token_t launch,
  output bclpd_pkg::event_t evt,
  output logic              done,
  output logic              tally_any
);
  import bclpd_pkg::*;

  token_t                 tok [NUM_BUTTONS+1];
  event_t                 cell_evt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] nz;

  assign tok[0] = launch;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_cell
    bclpd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .token_in  (tok[i]),
      .token_out (tok[i+1]),
      .evt       (cell_evt[i]),
      .tally_nz  (nz[i])
    );
  end

  always_comb begin
    evt = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (tok[i].act) evt = evt | cell_evt[i];
    end
  end

  assign done      = tok[NUM_BUTTONS].act;
  assign tally_any = |nz;

endmodule

>>> rtl/button_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered as the launch word and walks the cell
//   chain one button per cycle; a new item is taken only after every buffered
//   result of the last one (up to four) has been drained, one per cycle while
//   result_stall is low.
// Reset: synchronous, active high; all buttons idle, tallies and counters
//   zero, thresholds 500 and 25.
// ----------------------------------------------------------------------------
// button_click_long_press_detector: multi-click and long-press detector
// Accepts ticks and key events, walks them over the button cells and
// delivers the resulting event words with the busy flag.
// ----------------------------------------------------------------------------
module button_click_long_press_detector (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  bclpd_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output bclpd_pkg::result_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bclpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                 state;
  cfg_t                   cfg;
  token_t                 launch;
  event_t                 evt;
  event_t                 res [MAX_RES];
  logic [RES_CNT_W-1:0]   cnt;
  logic [RES_IDX_W-1:0]   rd;
  logic                   key_held;
  logic                   busy;
  logic                   done;
  logic                   tally_any;
  logic                   item_acc;
  logic                   res_acc;
  logic                   is_last;
  logic                   cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_RELEASE_GAP) ? 32'(cfg.release_gap_ticks)
                                                  : 32'(cfg.long_press_ticks);

  assign item_stall   = (state != S_IDLE);
  assign item_acc     = item_valid && !item_stall;
  assign result_valid = (state == S_OUT);
  assign res_acc      = result_valid && !result_stall;
  assign is_last      = (RES_CNT_W'(rd) + RES_CNT_W'(1)) == cnt;

  assign result.button_number = res[rd].btn;
  assign result.event_res     = res[rd].ev;
  assign result.click_count   = res[rd].cnt;
  assign result.busy_res      = busy;
  assign result.last          = is_last;

  bclpd_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .launch    (launch),
    .evt       (evt),
    .done      (done),
    .tally_any (tally_any)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks  <= LONG_PRESS_RST;
      cfg.release_gap_ticks <= RELEASE_GAP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LONG_PRESS) cfg.long_press_ticks <= pwdata[CFG_BITS-1:0];
      else cfg.release_gap_ticks <= pwdata[CFG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      launch.act <= 1'b0;
      key_held   <= 1'b0;
      cnt        <= '0;
      rd         <= '0;
    end else begin
      launch.act <= item_acc;
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            state <= S_RUN;
            cnt   <= '0;
            rd    <= '0;
            if (item.opcode == OP_PRESS) key_held <= 1'b1;
            else if (item.opcode == OP_RELEASE) key_held <= 1'b0;
          end
        end
        S_RUN: begin
          if (evt.fire && cnt < RES_CNT_W'(MAX_RES)) cnt <= cnt + RES_CNT_W'(1);
          if (done) begin
            state <= S_OUT;
            if (cnt == '0) cnt <= RES_CNT_W'(1);
          end
        end
        S_OUT: begin
          if (res_acc) begin
            if (is_last) state <= S_IDLE;
            else rd <= rd + RES_IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    launch.opcode     <= item.opcode;
    launch.key_valid  <= item.key_valid;
    launch.key_number <= item.key_number;
    launch.btn        <= 5'd1;
    if (state == S_RUN) begin
      if (evt.fire && cnt < RES_CNT_W'(MAX_RES)) res[cnt[RES_IDX_W-1:0]] <= evt;
      if (done) begin
        busy <= key_held | tally_any;
        if (cnt == '0) res[0] <= '0;
      end
    end
  end

endmodule
